// ----- hw/rtl/stereo_reverse_echo_defines.svh -----
// ----------------------------------------------------------------------------
// stereo_reverse_echo_defines: assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STEREO_REVERSE_ECHO_DEFINES_SVH
`define STEREO_REVERSE_ECHO_DEFINES_SVH

`ifndef SYNTHESIS
`define SRE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stereo_reverse_echo check failed");
`define SRE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stereo_reverse_echo check failed");
`else
`define SRE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SRE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/sre_pkg.sv -----
// ----------------------------------------------------------------------------
// sre_pkg: shared constants and helpers of the stereo reverse echo
// Fixed-point constants, register map and the constant-divider tables.
// ----------------------------------------------------------------------------
package sre_pkg;

    localparam logic [16:0] GAIN_ONE    = 17'd65536;
    localparam logic [24:0] Q24_ONE     = 25'd16777216;
    localparam logic [25:0] PI_Q24      = 26'd52707179;
    localparam logic [25:0] HALF_PI_Q24 = 26'd26353589;

    // Horner steps of the cosine: divide by 90, 56, 30, 12, then 2
    typedef logic [2:0] div_step_t;
    localparam div_step_t DIV_STEP_FIRST = 3'd0;
    localparam div_step_t DIV_STEP_LAST  = 3'd4;

    typedef enum logic [2:0] {
        REG_DELAY_LEN     = 3'd0,
        REG_LR_OFFSET     = 3'd1,
        REG_PAN_GAIN      = 3'd2,
        REG_CROSS_GAIN    = 3'd3,
        REG_FEEDBACK_GAIN = 3'd4,
        REG_DAMP_GAIN     = 3'd5,
        REG_REVERSE_GAIN  = 3'd6,
        REG_SWELL_STEP    = 3'd7
    } reg_index_t;

    localparam logic [17:0] RST_DELAY_LEN     = 18'd27121;
    localparam logic [18:0] RST_LR_OFFSET     = 19'd0;
    localparam logic [16:0] RST_PAN_GAIN      = 17'd33284;
    localparam logic [16:0] RST_CROSS_GAIN    = 17'd15480;
    localparam logic [16:0] RST_FEEDBACK_GAIN = 17'd30208;
    localparam logic [16:0] RST_DAMP_GAIN     = 17'd65536;
    localparam logic [16:0] RST_REVERSE_GAIN  = 17'd65536;
    localparam logic [23:0] RST_SWELL_STEP    = 24'd5243;

    function automatic logic [16:0] gain_clamp(input logic [16:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    function automatic logic [6:0] div_divisor(input div_step_t k);
        case (k)
            3'd0:    return 7'd90;
            3'd1:    return 7'd56;
            3'd2:    return 7'd30;
            3'd3:    return 7'd12;
            default: return 7'd2;
        endcase
    endfunction

    // floor(2^32 / divisor); estimate is low by at most one
    function automatic logic [31:0] div_recip(input div_step_t k);
        case (k)
            3'd0:    return 32'd47721858;
            3'd1:    return 32'd76695844;
            3'd2:    return 32'd143165576;
            3'd3:    return 32'd357913941;
            default: return 32'd2147483648;
        endcase
    endfunction

endpackage

// ----- hw/rtl/stereo_reverse_echo.sv -----
// ----------------------------------------------------------------------------
// stereo_reverse_echo: stereo feedback echo with reversed playback
// Two delay memories, cross-mixed feedback, damping lowpass, reverse blend
// with a cosine swell computed by multiplies and a reciprocal constant divider.
// ----------------------------------------------------------------------------
// Only one word is in flight: a new word is taken only after the result of
// the last one has been posted. How long a word takes is set by the
// cosine sequencer (five reciprocal-divide steps per channel) and by the
// single read port of each delay memory. Reset and any register write clear
// positions, lowpass memories and the fill count at once; no clearing pass.
`include "stereo_reverse_echo_defines.svh"

module stereo_reverse_echo #(
    parameter int DEPTH        = 131072,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       m_tdata,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [4:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int TW   = ((2*SW+7)/8)*8;
    localparam int AW   = $clog2(DEPTH);
    localparam int LW   = AW + 1;
    localparam int PW   = SW + 19;
    localparam int SUMW = SW + 20;
    localparam int PHW  = AW + 24;

    typedef enum logic [4:0] {
        ST_IDLE, ST_F_OLD, ST_F_MIX, ST_F_FB, ST_F_FBS, ST_F_DAMP, ST_F_WR,
        ST_O_ADDR, ST_O_FWD, ST_O_BACK, ST_C_Y2, ST_D_EST, ST_D_FIX, ST_C_MUL,
        ST_O_SWELL, ST_O_SCALE, ST_O_MUL, ST_O_SUM, ST_O_DONE
    } state_t;

    typedef enum logic [1:0] {MODE_FWD, MODE_PLAIN, MODE_SWELL} mode_t;

    // configuration
    logic [17:0] delay_len_reg;
    logic [18:0] lr_offset_reg;
    logic [16:0] pan_gain_reg, cross_gain_reg, feedback_gain_reg;
    logic [16:0] damp_gain_reg, reverse_gain_reg;
    logic [23:0] swell_step_reg;

    // derived settings
    logic [LW-1:0] len_l_reg, len_r_reg;
    logic [16:0]   pan_g_reg, pan_c_reg, cr_g_reg, cr_c_reg, fb_g_reg;
    logic [16:0]   hd_g_reg, hd_c_reg, rev_g_reg, rev_c_reg;
    logic signed [21:0] dl_sum, dr_sum, off_ext;

    // control
    state_t            state_reg;
    mode_t             mode_reg;
    logic              ch_reg;
    sre_pkg::div_step_t k_reg;
    logic [AW-1:0]     pos_l_reg, pos_r_reg, rpos_reg, dist_reg;
    logic [LW-1:0]     fill_reg;
    logic              m_tvalid_reg;
    logic [TW-1:0]     m_tdata_reg;
    logic              cfg_wr;

    // memories
    logic [SW-1:0] left_mem  [0:DEPTH-1];
    logic [SW-1:0] right_mem [0:DEPTH-1];
    logic [SW-1:0] left_rdata_reg, right_rdata_reg;
    logic [AW-1:0] rd_addr_l, rd_addr_r;
    logic          wr_en;

    // datapath
    logic signed [SW-1:0]   lin_reg, rin_reg, l_reg, r_reg, lp_l_reg, lp_r_reg;
    logic signed [SW:0]     lv_reg, rv_reg, a_reg;
    logic signed [PW-1:0]   p1_reg, p2_reg, p3_reg, p4_reg, m1_reg, m2_reg;
    logic signed [SW-1:0]   fwd_reg, back_reg, out_l_reg, out_r_reg;
    logic [PHW-1:0]         phase_reg;
    logic                   upper_reg;
    logic [25:0]            y_reg, y2_reg, num_reg, sw_reg;
    logic [24:0]            qe_reg, t_reg, cos_reg;

    logic signed [SW-1:0]   lold, rold, cur_rd, back_val, res_next;
    logic signed [SW-1:0]   vl_next, vr_next;
    logic [AW-1:0]          cur_pos, rpos_calc, dist_calc;
    logic [AW-1:0]          pos_l_next, pos_r_next;
    logic [LW-1:0]          cur_len, pos_l_inc, pos_r_inc;
    logic signed [SUMW-1:0] sum_a, sum_b, o_sum, fwd2;
    logic [51:0]            ysq;
    logic [57:0]            num_m;
    logic [31:0]            qc, rem;
    logic [24:0]            q_fix;
    logic [50:0]            y2t;
    logic signed [SW+26:0]  scale_prod;

    function automatic logic signed [SW-1:0] sat_sw(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi, lo;
        hi = $signed({{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return {1'b0, {(SW-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(SW-1){1'b0}}};
        end
        return v[SW-1:0];
    endfunction

    function automatic logic [LW-1:0] clamp_len(input logic signed [21:0] v);
        if (v < 22'sd1) begin
            return LW'(1);
        end else if (v > $signed(22'(DEPTH))) begin
            return LW'(DEPTH);
        end
        return LW'(v);
    endfunction

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign wr_en    = (state_reg == ST_F_WR);

    assign off_ext = 22'(signed'(lr_offset_reg));
    assign dl_sum  = $signed({4'b0, delay_len_reg}) - off_ext;
    assign dr_sum  = $signed({4'b0, delay_len_reg}) + off_ext;

    always_comb begin
        case (sre_pkg::reg_index_t'(paddr[4:2]))
            sre_pkg::REG_DELAY_LEN:     prdata = 32'(delay_len_reg);
            sre_pkg::REG_LR_OFFSET:     prdata = 32'(lr_offset_reg);
            sre_pkg::REG_PAN_GAIN:      prdata = 32'(pan_gain_reg);
            sre_pkg::REG_CROSS_GAIN:    prdata = 32'(cross_gain_reg);
            sre_pkg::REG_FEEDBACK_GAIN: prdata = 32'(feedback_gain_reg);
            sre_pkg::REG_DAMP_GAIN:     prdata = 32'(damp_gain_reg);
            sre_pkg::REG_REVERSE_GAIN:  prdata = 32'(reverse_gain_reg);
            sre_pkg::REG_SWELL_STEP:    prdata = 32'(swell_step_reg);
            default:                    prdata = '0;
        endcase
    end

    // memory read addresses: old entries on accept, then forward and mirrored
    always_comb begin
        case (state_reg)
            ST_O_ADDR: begin
                rd_addr_l = cur_pos;
                rd_addr_r = cur_pos;
            end
            ST_O_FWD: begin
                rd_addr_l = rpos_reg;
                rd_addr_r = rpos_reg;
            end
            default: begin
                rd_addr_l = pos_l_reg;
                rd_addr_r = pos_r_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            left_mem[pos_l_reg] <= vl_next;
        end
        left_rdata_reg <= left_mem[rd_addr_l];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            right_mem[pos_r_reg] <= vr_next;
        end
        right_rdata_reg <= right_mem[rd_addr_r];
    end

    always_comb begin
        // entries at or above the fill count were never written since a clear
        lold = ({1'b0, pos_l_reg} < fill_reg) ? $signed(left_rdata_reg) : '0;
        rold = ({1'b0, pos_r_reg} < fill_reg) ? $signed(right_rdata_reg) : '0;

        cur_pos  = ch_reg ? pos_r_reg : pos_l_reg;
        cur_len  = ch_reg ? len_r_reg : len_l_reg;
        cur_rd   = ch_reg ? $signed(right_rdata_reg) : $signed(left_rdata_reg);
        back_val = ({1'b0, rpos_reg} < fill_reg) ? cur_rd : '0;

        rpos_calc = AW'(cur_len - LW'(1) - {1'b0, cur_pos});
        dist_calc = (cur_pos >= rpos_calc) ? (cur_pos - rpos_calc) : (rpos_calc - cur_pos);

        sum_a   = SUMW'(p1_reg) + SUMW'(p2_reg);
        sum_b   = SUMW'(p3_reg) + SUMW'(p4_reg);
        vl_next = sat_sw(sum_a >>> 16);
        vr_next = sat_sw(sum_b >>> 16);

        pos_l_inc  = {1'b0, pos_l_reg} + LW'(1);
        pos_r_inc  = {1'b0, pos_r_reg} + LW'(1);
        pos_l_next = (pos_l_inc >= len_l_reg) ? '0 : pos_l_inc[AW-1:0];
        pos_r_next = (pos_r_inc >= len_r_reg) ? '0 : pos_r_inc[AW-1:0];

        ysq   = y_reg * y_reg;
        num_m = num_reg * sre_pkg::div_recip(k_reg);
        qc    = qe_reg * sre_pkg::div_divisor(k_reg);
        rem   = 32'(num_reg) - qc;
        q_fix = (rem >= 32'(sre_pkg::div_divisor(k_reg))) ? (qe_reg + 25'd1) : qe_reg;
        y2t   = y2_reg * t_reg;

        scale_prod = back_reg * $signed({1'b0, sw_reg});

        o_sum = SUMW'(m1_reg) + SUMW'(m2_reg);
        fwd2  = SUMW'(fwd_reg) <<< 1;
        case (mode_reg)
            MODE_FWD:   res_next = sat_sw(fwd2);
            MODE_SWELL: res_next = sat_sw(o_sum >>> 16);
            default:    res_next = sat_sw(o_sum >>> 15);
        endcase
    end

    always_ff @(posedge aclk) begin
        len_l_reg <= clamp_len(dl_sum);
        len_r_reg <= clamp_len(dr_sum);
        pan_g_reg <= sre_pkg::gain_clamp(pan_gain_reg);
        pan_c_reg <= sre_pkg::GAIN_ONE - sre_pkg::gain_clamp(pan_gain_reg);
        cr_g_reg  <= sre_pkg::gain_clamp(cross_gain_reg);
        cr_c_reg  <= sre_pkg::GAIN_ONE - sre_pkg::gain_clamp(cross_gain_reg);
        fb_g_reg  <= sre_pkg::gain_clamp(feedback_gain_reg);
        hd_g_reg  <= sre_pkg::gain_clamp(damp_gain_reg);
        hd_c_reg  <= sre_pkg::GAIN_ONE - sre_pkg::gain_clamp(damp_gain_reg);
        rev_g_reg <= sre_pkg::gain_clamp(reverse_gain_reg);
        rev_c_reg <= sre_pkg::GAIN_ONE - sre_pkg::gain_clamp(reverse_gain_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            mode_reg          <= MODE_FWD;
            ch_reg            <= 1'b0;
            k_reg             <= sre_pkg::DIV_STEP_FIRST;
            pos_l_reg         <= '0;
            pos_r_reg         <= '0;
            fill_reg          <= '0;
            lp_l_reg          <= '0;
            lp_r_reg          <= '0;
            m_tvalid_reg      <= 1'b0;
            delay_len_reg     <= sre_pkg::RST_DELAY_LEN;
            lr_offset_reg     <= sre_pkg::RST_LR_OFFSET;
            pan_gain_reg      <= sre_pkg::RST_PAN_GAIN;
            cross_gain_reg    <= sre_pkg::RST_CROSS_GAIN;
            feedback_gain_reg <= sre_pkg::RST_FEEDBACK_GAIN;
            damp_gain_reg     <= sre_pkg::RST_DAMP_GAIN;
            reverse_gain_reg  <= sre_pkg::RST_REVERSE_GAIN;
            swell_step_reg    <= sre_pkg::RST_SWELL_STEP;
        end else begin
            // a word taken while the next one is posting is replaced below
            if (m_tvalid_reg && m_tready && (state_reg != ST_O_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                case (sre_pkg::reg_index_t'(paddr[4:2]))
                    sre_pkg::REG_DELAY_LEN:     delay_len_reg     <= pwdata[17:0];
                    sre_pkg::REG_LR_OFFSET:     lr_offset_reg     <= pwdata[18:0];
                    sre_pkg::REG_PAN_GAIN:      pan_gain_reg      <= pwdata[16:0];
                    sre_pkg::REG_CROSS_GAIN:    cross_gain_reg    <= pwdata[16:0];
                    sre_pkg::REG_FEEDBACK_GAIN: feedback_gain_reg <= pwdata[16:0];
                    sre_pkg::REG_DAMP_GAIN:     damp_gain_reg     <= pwdata[16:0];
                    sre_pkg::REG_REVERSE_GAIN:  reverse_gain_reg  <= pwdata[16:0];
                    sre_pkg::REG_SWELL_STEP:    swell_step_reg    <= pwdata[23:0];
                    default:                    swell_step_reg    <= swell_step_reg;
                endcase
                pos_l_reg <= '0;
                pos_r_reg <= '0;
                fill_reg  <= '0;
                lp_l_reg  <= '0;
                lp_r_reg  <= '0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        lin_reg   <= $signed(s_tdata[SW-1:0]);
                        rin_reg   <= $signed(s_tdata[2*SW-1:SW]);
                        state_reg <= ST_F_OLD;
                    end
                end
                ST_F_OLD: begin
                    p1_reg    <= lold * $signed({1'b0, cr_c_reg});
                    p2_reg    <= rold * $signed({1'b0, cr_g_reg});
                    p3_reg    <= rold * $signed({1'b0, cr_c_reg});
                    p4_reg    <= lold * $signed({1'b0, cr_g_reg});
                    state_reg <= ST_F_MIX;
                end
                ST_F_MIX: begin
                    l_reg     <= SW'(sum_a >>> 16);
                    r_reg     <= SW'(sum_b >>> 16);
                    state_reg <= ST_F_FB;
                end
                ST_F_FB: begin
                    p1_reg    <= lin_reg * $signed({1'b0, pan_g_reg});
                    p2_reg    <= -(l_reg * $signed({1'b0, fb_g_reg}));
                    p3_reg    <= rin_reg * $signed({1'b0, pan_c_reg});
                    p4_reg    <= -(r_reg * $signed({1'b0, fb_g_reg}));
                    state_reg <= ST_F_FBS;
                end
                ST_F_FBS: begin
                    lv_reg    <= (SW+1)'(sum_a >>> 16);
                    rv_reg    <= (SW+1)'(sum_b >>> 16);
                    state_reg <= ST_F_DAMP;
                end
                ST_F_DAMP: begin
                    p1_reg    <= lv_reg * $signed({1'b0, hd_g_reg});
                    p2_reg    <= lp_l_reg * $signed({1'b0, hd_c_reg});
                    p3_reg    <= rv_reg * $signed({1'b0, hd_g_reg});
                    p4_reg    <= lp_r_reg * $signed({1'b0, hd_c_reg});
                    state_reg <= ST_F_WR;
                end
                ST_F_WR: begin
                    // memory write happens here; forward reads follow later
                    lp_l_reg  <= vl_next;
                    lp_r_reg  <= vr_next;
                    pos_l_reg <= pos_l_next;
                    pos_r_reg <= pos_r_next;
                    if (fill_reg != LW'(DEPTH)) begin
                        fill_reg <= fill_reg + LW'(1);
                    end
                    ch_reg    <= 1'b0;
                    state_reg <= ST_O_ADDR;
                end
                ST_O_ADDR: begin
                    rpos_reg  <= rpos_calc;
                    dist_reg  <= dist_calc;
                    state_reg <= ST_O_FWD;
                end
                ST_O_FWD: begin
                    fwd_reg   <= ({1'b0, cur_pos} < fill_reg) ? cur_rd : '0;
                    phase_reg <= dist_reg * swell_step_reg;
                    state_reg <= ST_O_BACK;
                end
                ST_O_BACK: begin
                    back_reg  <= back_val;
                    a_reg     <= (SW+1)'(back_val);
                    upper_reg <= (phase_reg > PHW'(sre_pkg::HALF_PI_Q24));
                    if (phase_reg > PHW'(sre_pkg::HALF_PI_Q24)) begin
                        y_reg <= sre_pkg::PI_Q24 - phase_reg[25:0];
                    end else begin
                        y_reg <= phase_reg[25:0];
                    end
                    if (rev_g_reg == '0) begin
                        mode_reg  <= MODE_FWD;
                        state_reg <= ST_O_SUM;
                    end else if (phase_reg >= PHW'(sre_pkg::PI_Q24)) begin
                        mode_reg  <= MODE_PLAIN;
                        state_reg <= ST_O_MUL;
                    end else begin
                        mode_reg  <= MODE_SWELL;
                        state_reg <= ST_C_Y2;
                    end
                end
                ST_C_Y2: begin
                    y2_reg    <= ysq[49:24];
                    num_reg   <= ysq[49:24];
                    k_reg     <= sre_pkg::DIV_STEP_FIRST;
                    state_reg <= ST_D_EST;
                end
                ST_D_EST: begin
                    qe_reg    <= num_m[56:32];
                    state_reg <= ST_D_FIX;
                end
                ST_D_FIX: begin
                    if (k_reg == sre_pkg::DIV_STEP_LAST) begin
                        cos_reg   <= (q_fix > sre_pkg::Q24_ONE) ? '0 : (sre_pkg::Q24_ONE - q_fix);
                        state_reg <= ST_O_SWELL;
                    end else begin
                        t_reg     <= sre_pkg::Q24_ONE - q_fix;
                        state_reg <= ST_C_MUL;
                    end
                end
                ST_C_MUL: begin
                    num_reg   <= y2t[49:24];
                    k_reg     <= k_reg + 3'd1;
                    state_reg <= ST_D_EST;
                end
                ST_O_SWELL: begin
                    // past the quarter turn, 1 - cos(x) = 1 + cos(pi - x)
                    sw_reg    <= upper_reg ? (26'(sre_pkg::Q24_ONE) + 26'(cos_reg))
                                           : (26'(sre_pkg::Q24_ONE) - 26'(cos_reg));
                    state_reg <= ST_O_SCALE;
                end
                ST_O_SCALE: begin
                    a_reg     <= (SW+1)'(scale_prod >>> 24);
                    state_reg <= ST_O_MUL;
                end
                ST_O_MUL: begin
                    m1_reg    <= a_reg * $signed({1'b0, rev_g_reg});
                    m2_reg    <= fwd_reg * $signed({1'b0, rev_c_reg});
                    state_reg <= ST_O_SUM;
                end
                ST_O_SUM: begin
                    if (ch_reg) begin
                        out_r_reg <= res_next;
                        state_reg <= ST_O_DONE;
                    end else begin
                        out_l_reg <= res_next;
                        ch_reg    <= 1'b1;
                        state_reg <= ST_O_ADDR;
                    end
                end
                ST_O_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= TW'({out_r_reg, out_l_reg});
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SRE_ASSERT_IMP(a_pos_in_len, aclk, aresetn, 1'b1, (pos_l_reg < len_l_reg) && (pos_r_reg < len_r_reg))
    `SRE_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= LW'(DEPTH))
    `SRE_ASSERT_NEXT(a_result_posted, aclk, aresetn, (state_reg == ST_O_DONE) && (!m_tvalid_reg || m_tready), m_tvalid_reg && (state_reg == ST_IDLE))

endmodule

// ----- tb/tb_stereo_reverse_echo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_reverse_echo: self-checking regression of the stereo reverse echo
// Runs phases of register settings over APB, streams stereo words through
// the block with random idling on both sides, and checks every output word
// against a local model of the echo lines, the lowpass and the reverse blend.
// ----------------------------------------------------------------------------
module tb_stereo_reverse_echo;

    localparam int DEPTH    = 131072;
    localparam int SW       = 24;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [SW-1:0] right;
        logic signed [SW-1:0] left;
    } stereo_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // left_in, right_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;       // left_out, right_out
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stereo_reverse_echo DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------- echo model ----------------
    logic [31:0]    regs [8];
    int             left_line [DEPTH];
    int             right_line [DEPTH];
    int unsigned    left_pos, right_pos;
    longint         left_lp, right_lp;
    const int       reg_bits [8] = '{18, 19, 17, 17, 17, 17, 17, 24};

    stereo_t        words_to_send [$];
    stereo_t        echo_expected [$];
    int             mismatches = 0;
    bit             quiet = 1'b0;
    bit             hold_req = 1'b0;

    function automatic void clear_lines();
        for (int i = 0; i < DEPTH; i++) begin
            left_line[i] = 0;
            right_line[i] = 0;
        end
        left_pos = 0;
        right_pos = 0;
        left_lp = 0;
        right_lp = 0;
    endfunction

    function automatic longint gain_of(sre_pkg::reg_index_t idx);
        longint g;
        g = longint'(regs[idx]);
        return (g > 65536) ? 65536 : g;
    endfunction

    function automatic longint sat_sample(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint unsigned cos_fix(longint unsigned y);
        longint unsigned y2, t, p;
        y2 = (y * y) >> 24;
        t = 64'd16777216 - y2 / 90;
        t = 64'd16777216 - ((y2 * t) >> 24) / 56;
        t = 64'd16777216 - ((y2 * t) >> 24) / 30;
        t = 64'd16777216 - ((y2 * t) >> 24) / 12;
        p = ((y2 * t) >> 24) / 2;
        return (p > 64'd16777216) ? 0 : 64'd16777216 - p;
    endfunction

    function automatic longint unsigned swell_fix(longint unsigned x);
        if (x <= 64'd26353589) return 64'd16777216 - cos_fix(x);
        return 64'd16777216 + cos_fix(64'd52707179 - x);
    endfunction

    function automatic int unsigned line_len(longint off);
        longint d;
        d = longint'(regs[sre_pkg::REG_DELAY_LEN]) + off;
        if (d < 1) d = 1;
        if (d > DEPTH) d = DEPTH;
        return 32'(d);
    endfunction

    function automatic longint tap_out(bit is_left, int unsigned pos, int unsigned len);
        longint rev, fwd, back, span, a;
        longint unsigned phase;
        int unsigned rpos;
        rev = gain_of(sre_pkg::REG_REVERSE_GAIN);
        fwd = is_left ? left_line[pos % DEPTH] : right_line[pos % DEPTH];
        if (rev == 0) return sat_sample(2 * fwd);
        rpos = len - 1 - pos;
        back = is_left ? left_line[rpos % DEPTH] : right_line[rpos % DEPTH];
        span = longint'(pos) - longint'(rpos);
        if (span < 0) span = -span;
        phase = span * longint'(regs[sre_pkg::REG_SWELL_STEP]);
        if (phase < 64'd52707179) begin
            a = (back * longint'(swell_fix(phase))) >>> 24;
            return sat_sample((a * rev + fwd * (65536 - rev)) >>> 16);
        end
        return sat_sample((2 * (back * rev + fwd * (65536 - rev))) >>> 16);
    endfunction

    function automatic stereo_t echo_step(stereo_t in_w);
        longint off, lin, rin, pan, cr, fb, hd, lold, rold, l, r, lv, rv;
        int unsigned dl, dr;
        stereo_t res;
        off = longint'($signed(regs[sre_pkg::REG_LR_OFFSET][18:0]));
        dl = line_len(-off);
        dr = line_len(off);
        lin = in_w.left;
        rin = in_w.right;
        pan = gain_of(sre_pkg::REG_PAN_GAIN);
        cr = gain_of(sre_pkg::REG_CROSS_GAIN);
        fb = gain_of(sre_pkg::REG_FEEDBACK_GAIN);
        hd = gain_of(sre_pkg::REG_DAMP_GAIN);
        left_pos = left_pos % DEPTH;
        right_pos = right_pos % DEPTH;
        lold = left_line[left_pos];
        rold = right_line[right_pos];
        l = (lold * (65536 - cr) + rold * cr) >>> 16;
        r = (rold * (65536 - cr) + lold * cr) >>> 16;
        lv = (lin * pan - l * fb) >>> 16;
        rv = (rin * (65536 - pan) - r * fb) >>> 16;
        lv = sat_sample((lv * hd + left_lp * (65536 - hd)) >>> 16);
        rv = sat_sample((rv * hd + right_lp * (65536 - hd)) >>> 16);
        left_line[left_pos] = 32'(lv);
        right_line[right_pos] = 32'(rv);
        left_lp = lv;
        right_lp = rv;
        left_pos++;
        if (left_pos >= dl) left_pos = 0;
        right_pos++;
        if (right_pos >= dr) right_pos = 0;
        res.left = SW'(tap_out(1'b1, left_pos, dl));
        res.right = SW'(tap_out(1'b0, right_pos, dr));
        return res;
    endfunction

    // ---------------- input driver ----------------
    int src_gap = 0;
    always @(posedge aclk) begin
        logic    nxt_valid;
        stereo_t w;
        nxt_valid = s_tvalid;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                echo_expected.push_back(echo_step(s_tdata));
            if (!s_tvalid || s_tready) begin
                nxt_valid = 1'b0;
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                end else if (words_to_send.size() > 0) begin
                    w = words_to_send.pop_front();
                    s_tdata <= w;
                    nxt_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 11);
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // ---------------- output side ----------------
    int sink_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
                sink_gap <= $urandom_range(1, 11);
        end
    end

    always @(posedge aclk) begin
        stereo_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (echo_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", m_tdata);
            end else begin
                want = echo_expected.pop_front();
                if (got.left !== want.left || got.right !== want.right) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                 want.left, got.left, want.right, got.right);
                end
            end
        end
    end

    // stall watchdog: cycles with no word or register write accepted
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else if (stall_cycles >= WD_LIMIT) begin
            $display("stereo_reverse_echo regression: fail");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // ---------------- sequencing ----------------
    task automatic reg_write(sre_pkg::reg_index_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        regs[idx] = val & ((32'd1 << reg_bits[idx]) - 1);
        clear_lines();
    endtask

    // checked mid-cycle so that edge updates have settled
    task automatic drain();
        @(negedge aclk);
        while (words_to_send.size() > 0 || echo_expected.size() > 0 || s_tvalid)
            @(negedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(65537, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    task automatic random_setup();
        reg_write(sre_pkg::REG_DELAY_LEN, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 262143)
                                                                        : $urandom_range(1, 200));
        reg_write(sre_pkg::REG_LR_OFFSET, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 524287)
                                                                        : 19'($signed($urandom_range(0, 80)) - 40));
        reg_write(sre_pkg::REG_PAN_GAIN, pick_gain());
        reg_write(sre_pkg::REG_CROSS_GAIN, pick_gain());
        reg_write(sre_pkg::REG_FEEDBACK_GAIN, pick_gain());
        reg_write(sre_pkg::REG_DAMP_GAIN, pick_gain());
        reg_write(sre_pkg::REG_REVERSE_GAIN, pick_gain());
        case ($urandom_range(0, 3))
            0: reg_write(sre_pkg::REG_SWELL_STEP, $urandom_range(0, 16777215));
            1: reg_write(sre_pkg::REG_SWELL_STEP, $urandom_range(0, 4000));
            default: reg_write(sre_pkg::REG_SWELL_STEP, $urandom_range(0, 400000));
        endcase
    endtask

    task automatic queue_random(int n);
        stereo_t w;
        for (int i = 0; i < n; i++) begin
            w.left = SW'($urandom);
            w.right = SW'($urandom);
            if ($urandom_range(0, 9) == 0) w.left = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            if ($urandom_range(0, 9) == 0) w.right = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            words_to_send.push_back(w);
        end
    endtask

    initial begin
        const logic [23:0] edge_vals [6] = '{24'h7fffff, 24'h800000, 24'h000000,
                                             24'hffffff, 24'h000001, 24'h400000};
        stereo_t w;
        for (int i = 0; i < 8; i++) regs[i] = 0;
        regs[sre_pkg::REG_DELAY_LEN] = 32'(sre_pkg::RST_DELAY_LEN);
        regs[sre_pkg::REG_LR_OFFSET] = 32'(sre_pkg::RST_LR_OFFSET);
        regs[sre_pkg::REG_PAN_GAIN] = 32'(sre_pkg::RST_PAN_GAIN);
        regs[sre_pkg::REG_CROSS_GAIN] = 32'(sre_pkg::RST_CROSS_GAIN);
        regs[sre_pkg::REG_FEEDBACK_GAIN] = 32'(sre_pkg::RST_FEEDBACK_GAIN);
        regs[sre_pkg::REG_DAMP_GAIN] = 32'(sre_pkg::RST_DAMP_GAIN);
        regs[sre_pkg::REG_REVERSE_GAIN] = 32'(sre_pkg::RST_REVERSE_GAIN);
        regs[sre_pkg::REG_SWELL_STEP] = 32'(sre_pkg::RST_SWELL_STEP);
        clear_lines();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, edge samples
        for (int i = 0; i < 6; i++) begin
            w.left = edge_vals[i];
            w.right = edge_vals[5 - i];
            words_to_send.push_back(w);
        end
        drain();

        // short lines, gains above one, full feedback: saturation and swell
        reg_write(sre_pkg::REG_DELAY_LEN, 3);
        reg_write(sre_pkg::REG_LR_OFFSET, 19'h7ffff);
        reg_write(sre_pkg::REG_PAN_GAIN, 131071);
        reg_write(sre_pkg::REG_CROSS_GAIN, 65536);
        reg_write(sre_pkg::REG_FEEDBACK_GAIN, 131071);
        reg_write(sre_pkg::REG_DAMP_GAIN, 40000);
        reg_write(sre_pkg::REG_REVERSE_GAIN, 30000);
        reg_write(sre_pkg::REG_SWELL_STEP, 1000000);
        for (int i = 0; i < 8; i++) begin
            w.left = edge_vals[i % 6];
            w.right = edge_vals[(i + 2) % 6];
            words_to_send.push_back(w);
        end
        drain();

        // clamped lengths at both ends, no reverse
        reg_write(sre_pkg::REG_DELAY_LEN, 262143);
        reg_write(sre_pkg::REG_LR_OFFSET, 19'h40000);
        reg_write(sre_pkg::REG_REVERSE_GAIN, 0);
        reg_write(sre_pkg::REG_SWELL_STEP, 24'hffffff);
        queue_random(6);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            random_setup();
            if (ph == 3) hold_req <= 1'b1;
            if (ph == 9) quiet <= 1'b1;
            queue_random(100);
            drain();
        end

        if (mismatches == 0)
            $display("stereo_reverse_echo regression: pass");
        else
            $display("stereo_reverse_echo regression: fail");
        $finish;
    end
endmodule
